// ===== sv/aopc_pkg.sv =====
// Shared types, constants and the polarity table of the accelerometer offset and
// polarity calibration block. Used by every module in this folder; depends on nothing.
`default_nettype none

package aopc_pkg;

   localparam int CAL_SAMPLES = 32;
   localparam int ADC_BITS    = 10;

   localparam int RAW_W  = 10;
   localparam int ACC_W  = 11;
   localparam int ZERO_W = 10;
   localparam int SUM_W  = RAW_W + $clog2(CAL_SAMPLES);
   localparam int CNT_W  = $clog2(CAL_SAMPLES);
   localparam int ORI_W  = 3;
   localparam int FUNC_W = 2;
   localparam int CSR_W  = 10;

   localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((33'd1 << ADC_BITS) - 33'd1);
   localparam logic [CNT_W-1:0] LAST_SAMPLE = CNT_W'(CAL_SAMPLES - 1);

   // Operation codes; the spare code behaves as a read.
   localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NORMAL   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INVERTED = 2'd2;

   // Run kinds share the codes of the calibration operations.
   localparam logic [FUNC_W-1:0] RUN_NONE = 2'd0;

   // Register indexes.
   localparam logic CSR_ORIENTATION      = 1'b0;
   localparam logic CSR_DEFAULT_YAW_ZERO = 1'b1;

   localparam logic [ZERO_W-1:0] DEFAULT_YAW_ZERO_RESET = 10'd643;

   // Mounting orientations.
   localparam logic [ORI_W-1:0] ORI_FORWARD    = 3'd0;
   localparam logic [ORI_W-1:0] ORI_VERTICAL   = 3'd1;
   localparam logic [ORI_W-1:0] ORI_UPSIDEDOWN = 3'd2;
   localparam logic [ORI_W-1:0] ORI_AFT        = 3'd3;
   localparam logic [ORI_W-1:0] ORI_SIDEWAYS   = 3'd4;

   // Zeros as they stand after an item.
   typedef struct packed {
      logic [ZERO_W-1:0] zero_roll;
      logic [ZERO_W-1:0] zero_pitch;
      logic [ZERO_W-1:0] zero_yaw;
      logic [ZERO_W-1:0] vertical_zero;
   } zero_set_type;

   typedef struct packed {
      logic inverted_done;
      logic normal_done;
      logic cal_applied;
   } status_type;

   // Per-axis negate flags: bit 0 roll, bit 1 pitch, bit 2 yaw.
   function automatic logic [2:0] pol_negate(input logic [ORI_W-1:0] ori);
      logic [2:0] neg;
      unique case (ori)
         ORI_FORWARD:    neg = 3'b000;
         ORI_VERTICAL:   neg = 3'b110;
         ORI_UPSIDEDOWN: neg = 3'b101;
         ORI_AFT:        neg = 3'b011;
         ORI_SIDEWAYS:   neg = 3'b010;
         default:        neg = 3'b000;
      endcase
      return neg;
   endfunction

endpackage

`default_nettype wire

// ===== sv/aopc_cal.sv =====
// Calibration state of the block: per-axis sums, sample count, zeros and done flags.
// Depends on aopc_pkg for widths, codes and the polarity table.
`default_nettype none

module aopc_cal (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             step,
   input  wire logic [aopc_pkg::FUNC_W-1:0]      func,
   input  wire logic [aopc_pkg::RAW_W-1:0]       raw_roll,
   input  wire logic [aopc_pkg::RAW_W-1:0]       raw_pitch,
   input  wire logic [aopc_pkg::RAW_W-1:0]       raw_yaw,
   input  wire logic [aopc_pkg::ORI_W-1:0]       orientation,
   input  wire logic [aopc_pkg::ZERO_W-1:0]      default_yaw_zero,
   output aopc_pkg::zero_set_type                zeros_next,
   output aopc_pkg::status_type                  status_next
);

   aopc_pkg::zero_set_type             zeros_ff, zeros_in;
   logic [aopc_pkg::ZERO_W-1:0]        upright_ff, upright_in;
   logic                               normal_ff, normal_in;
   logic                               inverted_ff, inverted_in;
   logic [aopc_pkg::SUM_W-1:0]         sum_roll_ff, sum_pitch_ff, sum_yaw_ff;
   logic [aopc_pkg::SUM_W-1:0]         sum_roll_in, sum_pitch_in, sum_yaw_in;
   logic [aopc_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [aopc_pkg::FUNC_W-1:0]        run_ff, run_in;

   logic                               is_cal, sampling, same_run, complete, applied;
   logic [aopc_pkg::SUM_W-1:0]         acc_roll_sum, acc_pitch_sum, acc_yaw_sum;
   logic [aopc_pkg::ZERO_W-1:0]        avg_roll, avg_pitch, avg_yaw;
   logic                               yaw_neg, truly_inverted;
   logic signed [aopc_pkg::ZERO_W+1:0] diff, half, moved;

   always_comb begin
      is_cal   = (func == aopc_pkg::FUNC_NORMAL) || (func == aopc_pkg::FUNC_INVERTED);
      sampling = (func == aopc_pkg::FUNC_NORMAL) ||
                 ((func == aopc_pkg::FUNC_INVERTED) && normal_ff);
      same_run = (run_ff == func);
      complete = sampling && same_run && (count_ff == aopc_pkg::LAST_SAMPLE);
      // A sample of another kind than the running one starts afresh.
      if (same_run) begin
         acc_roll_sum  = sum_roll_ff  + aopc_pkg::SUM_W'(raw_roll);
         acc_pitch_sum = sum_pitch_ff + aopc_pkg::SUM_W'(raw_pitch);
         acc_yaw_sum   = sum_yaw_ff   + aopc_pkg::SUM_W'(raw_yaw);
      end else begin
         acc_roll_sum  = aopc_pkg::SUM_W'(raw_roll);
         acc_pitch_sum = aopc_pkg::SUM_W'(raw_pitch);
         acc_yaw_sum   = aopc_pkg::SUM_W'(raw_yaw);
      end
      avg_roll  = aopc_pkg::ZERO_W'(acc_roll_sum  / aopc_pkg::CAL_SAMPLES);
      avg_pitch = aopc_pkg::ZERO_W'(acc_pitch_sum / aopc_pkg::CAL_SAMPLES);
      avg_yaw   = aopc_pkg::ZERO_W'(acc_yaw_sum   / aopc_pkg::CAL_SAMPLES);

      yaw_neg        = |(aopc_pkg::pol_negate(orientation) & 3'b100);
      truly_inverted = yaw_neg ? (avg_yaw > zeros_ff.zero_yaw)
                               : (avg_yaw < zeros_ff.zero_yaw);
      // Halfway move: the arithmetic shift rounds the half difference down.
      diff  = $signed({2'b00, upright_ff}) - $signed({2'b00, avg_yaw});
      half  = diff >>> 1;
      moved = $signed({2'b00, upright_ff}) - half;

      zeros_in    = zeros_ff;
      upright_in  = upright_ff;
      normal_in   = normal_ff;
      inverted_in = inverted_ff;
      applied     = 1'b0;
      sum_roll_in  = '0;
      sum_pitch_in = '0;
      sum_yaw_in   = '0;
      count_in     = '0;
      run_in       = aopc_pkg::RUN_NONE;

      if (sampling) begin
         run_in = func;
         if (!complete) begin
            sum_roll_in  = acc_roll_sum;
            sum_pitch_in = acc_pitch_sum;
            sum_yaw_in   = acc_yaw_sum;
            count_in     = same_run ? count_ff + 1'b1 : aopc_pkg::CNT_W'(1);
         end else if (func == aopc_pkg::FUNC_NORMAL) begin
            zeros_in.zero_roll     = avg_roll;
            zeros_in.zero_pitch    = avg_pitch;
            zeros_in.zero_yaw      = avg_yaw;
            zeros_in.vertical_zero = avg_yaw;
            upright_in             = avg_yaw;
            normal_in              = 1'b1;
            inverted_in            = 1'b0;
            applied                = 1'b1;
         end else if (truly_inverted) begin
            zeros_in.zero_yaw = moved[aopc_pkg::ZERO_W-1:0];
            inverted_in       = 1'b1;
            normal_in         = 1'b0;
            applied           = 1'b1;
         end
      end else if (!is_cal && !inverted_ff) begin
         zeros_in.zero_yaw = default_yaw_zero;
      end

      zeros_next                = zeros_in;
      status_next.cal_applied   = applied;
      status_next.normal_done   = normal_in;
      status_next.inverted_done = inverted_in;
   end

   // Calibration state registers; they load only on a step and are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         zeros_ff     <= '0;
         upright_ff   <= '0;
         normal_ff    <= 1'b0;
         inverted_ff  <= 1'b0;
         sum_roll_ff  <= '0;
         sum_pitch_ff <= '0;
         sum_yaw_ff   <= '0;
         count_ff     <= '0;
         run_ff       <= aopc_pkg::RUN_NONE;
      end else if (step) begin
         zeros_ff     <= zeros_in;
         upright_ff   <= upright_in;
         normal_ff    <= normal_in;
         inverted_ff  <= inverted_in;
         sum_roll_ff  <= sum_roll_in;
         sum_pitch_ff <= sum_pitch_in;
         sum_yaw_ff   <= sum_yaw_in;
         count_ff     <= count_in;
         run_ff       <= run_in;
      end
   end

   // The two done flags exclude each other.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(normal_ff && inverted_ff))
      else $error("normal and inverted calibration both marked done");

   // Inverted calibration can only be recorded once a normal one has been.
   a_inverted_needs_normal: assert property (@(posedge clock) disable iff (reset)
      step && !inverted_ff && inverted_in |-> normal_ff)
      else $error("inverted calibration applied without normal calibration");

   // No run carries on past a read.
   a_read_ends_run: assert property (@(posedge clock) disable iff (reset)
      step && !is_cal |=> (count_ff == '0) && (run_ff == aopc_pkg::RUN_NONE))
      else $error("calibration run survived a read");

endmodule

`default_nettype wire

// ===== sv/aopc_polarity.sv =====
// Read datapath: removes the per-axis zeros, applies the orientation polarity and
// forms the vertical value. Combinational; depends on aopc_pkg.
`default_nettype none

module aopc_polarity (
   input  wire logic [aopc_pkg::FUNC_W-1:0]   func,
   input  wire logic [aopc_pkg::RAW_W-1:0]    raw_roll,
   input  wire logic [aopc_pkg::RAW_W-1:0]    raw_pitch,
   input  wire logic [aopc_pkg::RAW_W-1:0]    raw_yaw,
   input  wire logic [aopc_pkg::ORI_W-1:0]    orientation,
   input  wire aopc_pkg::zero_set_type        zeros,
   output logic signed [aopc_pkg::ACC_W-1:0]  acc_roll,
   output logic signed [aopc_pkg::ACC_W-1:0]  acc_pitch,
   output logic signed [aopc_pkg::ACC_W-1:0]  acc_yaw,
   output logic signed [aopc_pkg::ACC_W-1:0]  acc_vertical
);

   logic                              is_read;
   logic [2:0]                        neg;
   logic signed [aopc_pkg::ACC_W:0]   d_roll, d_pitch, d_yaw, d_vert;
   logic signed [aopc_pkg::ACC_W:0]   p_roll, p_pitch, p_yaw;

   always_comb begin
      is_read = !((func == aopc_pkg::FUNC_NORMAL) || (func == aopc_pkg::FUNC_INVERTED));
      neg     = aopc_pkg::pol_negate(orientation);
      d_roll  = $signed({2'b00, raw_roll})  - $signed({2'b00, zeros.zero_roll});
      d_pitch = $signed({2'b00, raw_pitch}) - $signed({2'b00, zeros.zero_pitch});
      d_yaw   = $signed({2'b00, raw_yaw})   - $signed({2'b00, zeros.zero_yaw});
      d_vert  = $signed({2'b00, raw_yaw})   - $signed({2'b00, zeros.vertical_zero});
      p_roll  = neg[0] ? -d_roll  : d_roll;
      p_pitch = neg[1] ? -d_pitch : d_pitch;
      p_yaw   = neg[2] ? -d_yaw   : d_yaw;
      acc_roll     = is_read ? p_roll[aopc_pkg::ACC_W-1:0]  : '0;
      acc_pitch    = is_read ? p_pitch[aopc_pkg::ACC_W-1:0] : '0;
      acc_yaw      = is_read ? p_yaw[aopc_pkg::ACC_W-1:0]   : '0;
      acc_vertical = d_vert[aopc_pkg::ACC_W-1:0];
   end

endmodule

`default_nettype wire

// ===== sv/accel_offset_polarity_calibration.sv =====
// Top level of the accelerometer offset and polarity calibration block: register file,
// input register, result register. Depends on aopc_pkg, aopc_cal and aopc_polarity.
//
//   channel  direction  tdata (low bit up)                        tuser (low bit up)
//   req_     in         raw_roll, raw_pitch, raw_yaw (32 bits)     func (2 bits)
//   rsp_     out        acc_roll, acc_pitch, acc_yaw, acc_vertical cal_applied,
//                       (48 bits)                                  normal_done, inverted_done
//   csr_     in         csr_we, csr_index, csr_wdata: orientation (0), default_yaw_zero (1)
//
// One beat per cycle is sustained while rsp_tready stays high. An accepted beat is held in
// the input register until the result register can take it; then the calibration state and
// its result are computed from it and written to their registers at the same edge.
// Reset is synchronous: both registers empty, zeros and flags cleared, registers at default.
// A stalled result holds; the input register then accepts one more beat and waits.
`default_nettype none

module accel_offset_polarity_calibration (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // raw_roll, raw_pitch, raw_yaw, zero fill
   input  wire logic [1:0]  req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // acc_roll, acc_pitch, acc_yaw, acc_vertical, fill
   output logic [2:0]       rsp_tuser,   // cal_applied, normal_done, inverted_done
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [9:0]  csr_wdata
);

   localparam int RW = aopc_pkg::RAW_W;
   localparam int AW = aopc_pkg::ACC_W;

   logic [aopc_pkg::ORI_W-1:0]   orientation_ff;
   logic [aopc_pkg::ZERO_W-1:0]  default_yaw_ff;

   logic                         in_valid_ff, in_valid_in;
   logic [aopc_pkg::FUNC_W-1:0]  func_ff;
   logic [RW-1:0]                roll_ff, pitch_ff, yaw_ff;

   logic                         out_valid_ff, out_valid_in;
   logic [47:0]                  out_data_ff;
   aopc_pkg::status_type         out_status_ff;

   logic                         advance, req_beat;
   aopc_pkg::zero_set_type       zeros_next;
   aopc_pkg::status_type         status_next;
   logic signed [AW-1:0]         acc_roll, acc_pitch, acc_yaw, acc_vertical;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orientation_ff <= aopc_pkg::ORI_FORWARD;
         default_yaw_ff <= aopc_pkg::DEFAULT_YAW_ZERO_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            aopc_pkg::CSR_ORIENTATION:      orientation_ff <= csr_wdata[aopc_pkg::ORI_W-1:0];
            aopc_pkg::CSR_DEFAULT_YAW_ZERO: default_yaw_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff  <= req_tuser;
         roll_ff  <= req_tdata[RW-1:0]    & aopc_pkg::ADC_MASK;
         pitch_ff <= req_tdata[2*RW-1:RW] & aopc_pkg::ADC_MASK;
         yaw_ff   <= req_tdata[3*RW-1:2*RW] & aopc_pkg::ADC_MASK;
      end
      if (advance) begin
         out_data_ff   <= {4'b0000, acc_vertical, acc_yaw, acc_pitch, acc_roll};
         out_status_ff <= status_next;
      end
   end

   aopc_cal u_cal (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .func             (func_ff),
      .raw_roll         (roll_ff),
      .raw_pitch        (pitch_ff),
      .raw_yaw          (yaw_ff),
      .orientation      (orientation_ff),
      .default_yaw_zero (default_yaw_ff),
      .zeros_next       (zeros_next),
      .status_next      (status_next)
   );

   aopc_polarity u_polarity (
      .func         (func_ff),
      .raw_roll     (roll_ff),
      .raw_pitch    (pitch_ff),
      .raw_yaw      (yaw_ff),
      .orientation  (orientation_ff),
      .zeros        (zeros_next),
      .acc_roll     (acc_roll),
      .acc_pitch    (acc_pitch),
      .acc_yaw      (acc_yaw),
      .acc_vertical (acc_vertical)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = {out_status_ff.inverted_done, out_status_ff.normal_done,
                        out_status_ff.cal_applied};

   // A stalled result with a waiting beat behind it blocks further input.
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while both registers are full");

   // Calibration beats report no axis values; checked on those that apply a calibration.
   a_cal_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[3*AW-1:0] == '0))
      else $error("calibration beat carries axis values");

   // An applied calibration leaves exactly one done flag set.
   a_applied_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tuser[1] != rsp_tuser[2]))
      else $error("applied calibration with inconsistent done flags");

endmodule

`default_nettype wire
